>>> rtl/core/dltts_pkg.sv
// ----------------------------------------------------------------------------
// dltts_pkg
// Shared types and constants of the delta-list task timer scheduler.
// ----------------------------------------------------------------------------
package dltts_pkg;

    localparam int TaskSlots = 16;
    localparam int SlotW     = $clog2(TaskSlots + 1);
    localparam int IdxW      = $clog2(TaskSlots);
    localparam int FifoDepth = TaskSlots + 2;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam logic [SlotW-1:0] NoneSlot = SlotW'(TaskSlots);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DELETE   = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [15:0] task_tag;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic        op_ok;
        logic [31:0] task_id_out;
        logic [15:0] tag_out;
        logic [4:0]  became_due;
    } rsp_t;

    // controller -> datapath step commands
    typedef enum logic [3:0] {
        C_NOP, C_LOAD, C_TICK_DEC, C_TICK_POP, C_ADD_ALLOC, C_LINK_WALK,
        C_LINK_DONE, C_DEL_FIND, C_DEL_APPLY, C_DSP_POP, C_FINISH
    } cmd_t;

    typedef struct packed {
        logic head_due;      // head valid with zero delay
        logic walk_stop;     // link walk reached its place
        logic disp_stop;     // dispatch done (found or empty), or no due head left on a tick
        logic disp_link;     // dispatched task needs relinking
        logic alloc_ok;      // add may proceed
        logic del_found;
    } stat_t;

endpackage

>>> rtl/core/dltts_ctrl.sv
// ----------------------------------------------------------------------------
// dltts_ctrl
// Sequencer of the scheduler: steps one request through the datapath.
// ----------------------------------------------------------------------------
module dltts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [1:0]           op,
    input  dltts_pkg::stat_t     stat,
    input  logic                 out_free,
    output dltts_pkg::cmd_t      cmd,
    output logic                 busy
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DISP = 7'b0000010,
        S_TICK = 7'b0000100,
        S_ADD  = 7'b0001000,
        S_WALK = 7'b0010000,
        S_DEL  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = dltts_pkg::C_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd = dltts_pkg::C_LOAD;
                    unique case (dltts_pkg::op_t'(op))
                        dltts_pkg::OP_TICK:     state_next = S_TICK;
                        dltts_pkg::OP_ADD:      state_next = S_ADD;
                        dltts_pkg::OP_DELETE:   state_next = S_DEL;
                        dltts_pkg::OP_DISPATCH: state_next = S_DISP;
                        default:                state_next = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                cmd = dltts_pkg::C_TICK_DEC;
                state_next = S_DISP;
            end
            S_DISP: begin
                // S_DISP after tick decrement drains due heads; otherwise dispatch
                cmd = dltts_pkg::C_DSP_POP;
                if (stat.disp_stop) begin
                    state_next = stat.disp_link ? S_WALK : S_DONE;
                end
            end
            S_ADD: begin
                cmd = dltts_pkg::C_ADD_ALLOC;
                state_next = stat.alloc_ok ? S_WALK : S_DONE;
            end
            S_WALK: begin
                cmd = stat.walk_stop ? dltts_pkg::C_LINK_DONE : dltts_pkg::C_LINK_WALK;
                if (stat.walk_stop) begin
                    state_next = S_DONE;
                end
            end
            S_DEL: begin
                cmd = dltts_pkg::C_DEL_APPLY;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd = dltts_pkg::C_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/dltts_dp.sv
// ----------------------------------------------------------------------------
// dltts_dp
// Datapath of the scheduler: slot pool, delta list, ready FIFO.
// ----------------------------------------------------------------------------
module dltts_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dltts_pkg::cmd_t      cmd,
    input  dltts_pkg::req_t      req,
    output dltts_pkg::stat_t     stat,
    output dltts_pkg::rsp_t      rsp
);
    localparam int N  = dltts_pkg::TaskSlots;
    localparam int SW = dltts_pkg::SlotW;
    localparam int IW = dltts_pkg::IdxW;
    localparam int PW = dltts_pkg::PtrW;
    localparam int FD = dltts_pkg::FifoDepth;

    logic [31:0]   delay_reg [N];
    logic [31:0]   period_reg [N];
    logic [31:0]   id_reg [N];
    logic [15:0]   tag_reg [N];
    logic [SW-1:0] next_reg [N];
    logic [SW-1:0] prev_reg [N];
    logic [N-1:0]  used_reg;
    logic [N-1:0]  canc_reg;
    logic [SW-1:0] head_reg;
    logic [31:0]   fresh_reg;
    logic [IW-1:0] fifo_mem [FD];
    logic [PW-1:0] wp_reg, rp_reg;

    dltts_pkg::req_t req_reg;
    dltts_pkg::rsp_t rsp_reg;
    logic          is_tick_reg;
    logic [IW-1:0] sel_reg;       // slot being linked in
    logic [31:0]   left_reg;
    logic [SW-1:0] cur_reg, bef_reg;
    logic [SW-1:0] guard_reg;

    assign rsp = rsp_reg;

    // lowest free slot
    logic [IW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    // lowest used slot with matching id
    logic [IW-1:0] hit_idx;
    logic          hit_any;
    always_comb begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            if (used_reg[i] && id_reg[i] == req_reg.target_id) begin
                hit_idx = IW'(i);
                hit_any = 1'b1;
            end
        end
    end

    logic          head_v;
    logic [IW-1:0] head_i;
    assign head_v = (head_reg != dltts_pkg::NoneSlot);
    assign head_i = head_reg[IW-1:0];

    logic          cur_v;
    logic [IW-1:0] cur_i;
    assign cur_v = (cur_reg != dltts_pkg::NoneSlot);
    assign cur_i = cur_reg[IW-1:0];

    logic [PW-1:0] wp_step, rp_step;
    assign wp_step = (wp_reg == PW'(FD - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_step = (rp_reg == PW'(FD - 1)) ? '0 : rp_reg + 1'b1;

    logic [IW-1:0] fifo_out;
    assign fifo_out = fifo_mem[rp_reg];
    logic          fifo_live;
    assign fifo_live = used_reg[fifo_out] && !canc_reg[fifo_out] && tag_reg[fifo_out] != 16'd0;

    always_comb begin
        stat.head_due  = head_v && delay_reg[head_i] == 32'd0;
        stat.walk_stop = !cur_v || left_reg <= delay_reg[cur_i] || guard_reg == SW'(N);
        if (is_tick_reg) begin
            stat.disp_stop = !stat.head_due;
            stat.disp_link = 1'b0;
        end else begin
            stat.disp_stop = (rp_reg == wp_reg) || fifo_live;
            stat.disp_link = (rp_reg != wp_reg) && fifo_live && period_reg[fifo_out] != 32'd0;
        end
        stat.alloc_ok  = free_any && req_reg.task_tag != 16'd0;
        stat.del_found = hit_any && req_reg.target_id != 32'd0;
    end

    logic [32:0] sum;
    logic        del_wait;
    logic [SW-1:0] hp, hq;
    assign hp  = prev_reg[hit_idx];
    assign hq  = next_reg[hit_idx];
    assign sum = {1'b0, delay_reg[hq[IW-1:0]]} + {1'b0, delay_reg[hit_idx]};
    assign del_wait = head_reg == {1'b0, hit_idx} || hp != dltts_pkg::NoneSlot
                      || hq != dltts_pkg::NoneSlot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                delay_reg[i]  <= '0;
                period_reg[i] <= '0;
                id_reg[i]     <= '0;
                tag_reg[i]    <= '0;
                next_reg[i]   <= dltts_pkg::NoneSlot;
                prev_reg[i]   <= dltts_pkg::NoneSlot;
            end
            used_reg    <= '0;
            canc_reg    <= '0;
            head_reg    <= dltts_pkg::NoneSlot;
            fresh_reg   <= 32'd1;
            wp_reg      <= '0;
            rp_reg      <= '0;
            is_tick_reg <= 1'b0;
        end else begin
            unique case (cmd)
                dltts_pkg::C_LOAD: begin
                    req_reg     <= req;
                    rsp_reg     <= '0;
                    is_tick_reg <= req.operation == dltts_pkg::OP_TICK;
                    cur_reg     <= head_reg;
                    bef_reg     <= dltts_pkg::NoneSlot;
                    guard_reg   <= '0;
                end
                dltts_pkg::C_TICK_DEC: begin
                    rsp_reg.op_ok <= 1'b1;
                    if (head_v && delay_reg[head_i] != 32'd0) begin
                        delay_reg[head_i] <= delay_reg[head_i] - 32'd1;
                    end
                end
                dltts_pkg::C_DSP_POP: begin
                    if (is_tick_reg) begin
                        if (stat.head_due) begin
                            head_reg <= next_reg[head_i];
                            if (next_reg[head_i] != dltts_pkg::NoneSlot) begin
                                prev_reg[next_reg[head_i][IW-1:0]] <= dltts_pkg::NoneSlot;
                            end
                            next_reg[head_i] <= dltts_pkg::NoneSlot;
                            prev_reg[head_i] <= dltts_pkg::NoneSlot;
                            if (wp_step == rp_reg) begin
                                used_reg[head_i] <= 1'b0;
                            end else begin
                                fifo_mem[wp_reg] <= head_i;
                                wp_reg <= wp_step;
                                rsp_reg.became_due <= rsp_reg.became_due + 5'd1;
                            end
                        end
                    end else if (rp_reg != wp_reg) begin
                        rp_reg <= rp_step;
                        if (!fifo_live) begin
                            used_reg[fifo_out] <= 1'b0;
                        end else begin
                            rsp_reg.op_ok       <= 1'b1;
                            rsp_reg.task_id_out <= id_reg[fifo_out];
                            rsp_reg.tag_out     <= tag_reg[fifo_out];
                            if (period_reg[fifo_out] == 32'd0) begin
                                used_reg[fifo_out] <= 1'b0;
                            end
                            sel_reg  <= fifo_out;
                            left_reg <= period_reg[fifo_out];
                        end
                    end
                end
                dltts_pkg::C_ADD_ALLOC: begin
                    if (stat.alloc_ok) begin
                        used_reg[free_idx]   <= 1'b1;
                        canc_reg[free_idx]   <= 1'b0;
                        period_reg[free_idx] <= req_reg.repeat_period;
                        tag_reg[free_idx]    <= req_reg.task_tag;
                        id_reg[free_idx]     <= fresh_reg;
                        fresh_reg <= (fresh_reg == 32'hFFFF_FFFF) ? 32'd1 : fresh_reg + 32'd1;
                        rsp_reg.op_ok        <= 1'b1;
                        rsp_reg.task_id_out  <= fresh_reg;
                        sel_reg  <= free_idx;
                        left_reg <= req_reg.start_delay;
                    end
                end
                dltts_pkg::C_LINK_WALK: begin
                    left_reg  <= left_reg - delay_reg[cur_i];
                    bef_reg   <= cur_reg;
                    cur_reg   <= next_reg[cur_i];
                    guard_reg <= guard_reg + 1'b1;
                end
                dltts_pkg::C_LINK_DONE: begin
                    delay_reg[sel_reg] <= left_reg;
                    prev_reg[sel_reg]  <= bef_reg;
                    next_reg[sel_reg]  <= cur_reg;
                    if (cur_v) begin
                        prev_reg[cur_i]  <= {1'b0, sel_reg};
                        delay_reg[cur_i] <= delay_reg[cur_i] - left_reg;
                    end
                    if (bef_reg != dltts_pkg::NoneSlot) begin
                        next_reg[bef_reg[IW-1:0]] <= {1'b0, sel_reg};
                    end else begin
                        head_reg <= {1'b0, sel_reg};
                    end
                end
                dltts_pkg::C_DEL_APPLY: begin
                    if (stat.del_found) begin
                        rsp_reg.op_ok <= 1'b1;
                        if (del_wait) begin
                            if (hq != dltts_pkg::NoneSlot) begin
                                delay_reg[hq[IW-1:0]] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                                prev_reg[hq[IW-1:0]]  <= hp;
                            end
                            if (hp != dltts_pkg::NoneSlot) begin
                                next_reg[hp[IW-1:0]] <= hq;
                            end else begin
                                head_reg <= hq;
                            end
                            prev_reg[hit_idx] <= dltts_pkg::NoneSlot;
                            next_reg[hit_idx] <= dltts_pkg::NoneSlot;
                            used_reg[hit_idx] <= 1'b0;
                        end else begin
                            canc_reg[hit_idx] <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (cmd == dltts_pkg::C_DSP_POP && !is_tick_reg && stat.disp_link) begin
                cur_reg   <= head_reg;
                bef_reg   <= dltts_pkg::NoneSlot;
                guard_reg <= '0;
            end
            if (cmd == dltts_pkg::C_ADD_ALLOC) begin
                cur_reg   <= head_reg;
                bef_reg   <= dltts_pkg::NoneSlot;
                guard_reg <= '0;
            end
        end
    end
endmodule

>>> rtl/core/delta_list_task_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// delta_list_task_timer_scheduler_top
// Task timer with a delta-ordered wait list and a ready FIFO.
//
// channel  dir  fields (tdata, lowest bit first)
// s_axis   in   operation[1:0] start_delay[33:2] repeat_period[65:34]
//               task_tag[81:66] target_id[113:82]
// m_axis   out  op_ok[0] task_id_out[32:1] tag_out[48:33] became_due[53:49]
//
// One request at a time. Delete loads, applies and finishes; add loads,
// allocates and, when accepted, walks the list (up to TaskSlots - 1
// entries) and links; tick decrements the head and drains due heads;
// dispatch skips cancelled or stale FIFO entries and walks and relinks a
// periodic task. The list walk takes one slot per cycle. Reset is
// synchronous and clears all slots at once. A request that finishes while the
// result register is full holds in its last step until the register drains.
// ----------------------------------------------------------------------------
module delta_list_task_timer_scheduler_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // operation, start_delay, repeat_period, task_tag, target_id
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata    // op_ok, task_id_out, tag_out, became_due
);
    dltts_pkg::cmd_t  cmd;
    dltts_pkg::stat_t stat;
    dltts_pkg::rsp_t  rsp;
    dltts_pkg::req_t  req;
    logic busy;
    logic mvalid_reg;
    logic [53:0] mdata_reg;

    assign req.operation     = s_tdata[1:0];
    assign req.start_delay   = s_tdata[33:2];
    assign req.repeat_period = s_tdata[65:34];
    assign req.task_tag      = s_tdata[81:66];
    assign req.target_id     = s_tdata[113:82];

    assign s_tready = !busy;

    dltts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(s_tvalid), .op(s_tdata[1:0]),
        .stat(stat), .out_free(!mvalid_reg || m_tready), .cmd(cmd), .busy(busy)
    );

    dltts_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .req(req), .stat(stat), .rsp(rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd == dltts_pkg::C_FINISH) begin
            mvalid_reg <= 1'b1;
            mdata_reg  <= {rsp.became_due, rsp.tag_out, rsp.task_id_out, rsp.op_ok};
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, mdata_reg};
endmodule
